FILE: hw/rtl/dlr_pkg.sv
// Shared types, codes and defaults of the dense layer with ReLU.
`default_nettype none

package dlr_pkg;

	// Fixed field widths of the transactions
	localparam int CMD_W  = 2;
	localparam int IDX_W  = 4;
	localparam int VAL_W  = 16;
	localparam int BIAS_W = 32;
	localparam int ACT_W  = 31;

	// Defaults of the top-level parameters
	localparam int N_DEF      = 16;
	localparam int DATA_W_DEF = 16;
	localparam int ACC_W_DEF  = 32;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_WEIGHT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BIAS   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FEED,
		ST_FLUSH,
		ST_LOAD,
		ST_DRAIN
	} state_t;

	// Control bits that travel with a sample element along the cell row
	typedef struct packed {
		logic v;
		logic first;
		logic last;
	} strm_ctl_t;

	// Store write strobes broadcast to the cells
	typedef struct packed {
		logic wen;
		logic ben;
	} wr_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dlr_if.sv
// Valid/ready channel interfaces for command items and activation results.
`default_nettype none

interface dlr_in_if;
	import dlr_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic [IDX_W-1:0]         input_index;
	logic [IDX_W-1:0]         neuron_index;
	logic signed [VAL_W-1:0]  value;
	logic signed [BIAS_W-1:0] bias_value;
	logic                     sample_last;

	modport source (
		output valid, cmd, input_index, neuron_index, value, bias_value, sample_last,
		input  ready
	);
	modport sink (
		input  valid, cmd, input_index, neuron_index, value, bias_value, sample_last,
		output ready
	);
endinterface

interface dlr_out_if;
	import dlr_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] out_neuron;
	logic [ACT_W-1:0] activation;
	logic             last_of_sample;

	modport source (
		output valid, out_neuron, activation, last_of_sample,
		input  ready
	);
	modport sink (
		input  valid, out_neuron, activation, last_of_sample,
		output ready
	);
endinterface

`default_nettype wire

FILE: hw/rtl/dlr_cell.sv
// One neuron cell: weight column, bias, MAC accumulator and result shift stage.
`default_nettype none

module dlr_cell #(
	parameter  int N        = dlr_pkg::N_DEF,
	parameter  int DATA_W   = dlr_pkg::DATA_W_DEF,
	parameter  int ACC_W    = dlr_pkg::ACC_W_DEF,
	parameter  int CELL_IDX = 0,
	localparam int KW       = (N > 1) ? $clog2(N) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// store writes
	input  dlr_pkg::wr_ctl_t               wr,
	input  logic [dlr_pkg::IDX_W-1:0]      wr_neuron,
	input  logic [KW-1:0]                  wr_k,
	input  logic [DATA_W-1:0]              wr_w,
	input  logic [ACC_W-1:0]               wr_b,
	// sample stream from the left neighbour and on to the right one
	input  dlr_pkg::strm_ctl_t             ctl_in,
	input  logic signed [DATA_W-1:0]       x_in,
	input  logic [KW-1:0]                  k_in,
	output dlr_pkg::strm_ctl_t             ctl_out,
	output logic signed [DATA_W-1:0]       x_out,
	output logic [KW-1:0]                  k_out,
	// result chain towards the output
	input  logic                           capture,
	input  logic                           shift,
	input  logic [dlr_pkg::ACT_W-1:0]      res_in,
	output logic [dlr_pkg::ACT_W-1:0]      res_out
);
	import dlr_pkg::*;

	localparam int PW = 2 * DATA_W;

	logic [DATA_W-1:0]        wmem [N];
	logic                     hit;
	logic signed [DATA_W-1:0] w_s1;
	logic signed [DATA_W-1:0] x_s1;
	logic [KW-1:0]            k_s1;
	strm_ctl_t                ctl_s1;
	logic signed [PW-1:0]     prod_full;
	logic [ACC_W-1:0]         prod_ext;
	logic [ACC_W-1:0]         prod_s2;
	strm_ctl_t                ctl_s2;
	logic [ACC_W-1:0]         bias_q;
	logic [ACC_W-1:0]         acc_q;
	logic [ACT_W-1:0]         act_d;
	logic [ACT_W-1:0]         res_q;

	assign hit = (int'(wr_neuron) == CELL_IDX);

	// weight column: one write port, registered read at the streamed index
	always_ff @(posedge clk) begin
		if (wr.wen && hit) begin
			wmem[wr_k] <= wr_w;
		end
		w_s1 <= wmem[k_in];
	end

	// bias word
	always_ff @(posedge clk) begin
		if (wr.ben && hit) begin
			bias_q <= wr_b;
		end
	end

	// stage 1 payload, also handed to the right neighbour
	always_ff @(posedge clk) begin
		x_s1 <= x_in;
		k_s1 <= k_in;
	end

	// stream control through both stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

	assign ctl_out = ctl_s1;
	assign x_out   = x_s1;
	assign k_out   = k_s1;

	// product, wrapped or sign-extended to the accumulator width
	assign prod_full = x_s1 * w_s1;

	generate
		if (ACC_W > PW) begin : g_prod_sext
			assign prod_ext = {{(ACC_W - PW){prod_full[PW-1]}}, prod_full};
		end else begin : g_prod_wrap
			assign prod_ext = prod_full[ACC_W-1:0];
		end
	endgenerate

	always_ff @(posedge clk) begin
		prod_s2 <= prod_ext;
	end

	// accumulate; the first element starts from the bias
	always_ff @(posedge clk) begin
		if (ctl_s2.v) begin
			acc_q <= (ctl_s2.first ? bias_q : acc_q) + prod_s2;
		end
	end

	// ReLU, saturating where the accumulator is wider than the activation plus a sign bit
	generate
		if (ACC_W > ACT_W + 1) begin : g_act_sat
			always_comb begin
				if (acc_q[ACC_W-1]) begin
					act_d = '0;
				end else if (|acc_q[ACC_W-2:ACT_W]) begin
					act_d = '1;
				end else begin
					act_d = acc_q[ACT_W-1:0];
				end
			end
		end else begin : g_act_fit
			assign act_d = acc_q[ACC_W-1] ? '0 : ACT_W'(acc_q[ACC_W-2:0]);
		end
	endgenerate

	// result chain: load all cells at once, then shift towards cell 0
	always_ff @(posedge clk) begin
		if (capture) begin
			res_q <= act_d;
		end else if (shift) begin
			res_q <= res_in;
		end
	end

	assign res_out = res_q;

endmodule

`default_nettype wire

FILE: hw/rtl/dense_layer_relu.sv
// Dense layer with bias and ReLU: a row of N neuron cells fed by a systolic sample stream.
// Weight, bias and non-final sample element writes are taken back to back while idle.
// A final sample element feeds the buffered sample into the N-cell stream; when it ends,
// all cells capture their activations, which then leave one per cycle while the receiver
// is ready. No transaction is taken until the last activation has left. Reset clears the
// sequencer, counters and stream control only; stores stay undefined until written.
`default_nettype none

module dense_layer_relu #(
	parameter int N      = dlr_pkg::N_DEF,
	parameter int DATA_W = dlr_pkg::DATA_W_DEF,
	parameter int ACC_W  = dlr_pkg::ACC_W_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	dlr_in_if.sink    item,
	dlr_out_if.source result
);
	import dlr_pkg::*;

	localparam int KW = (N > 1) ? $clog2(N) : 1;
	localparam logic [KW-1:0] K_LAST = KW'(N - 1);

	state_t                   state_q, state_d;
	logic                     in_acc, out_acc;
	logic                     k_ok, j_ok;
	logic [KW-1:0]            k_idx;
	logic [DATA_W-1:0]        val_d;
	logic [ACC_W-1:0]         bias_d;
	wr_ctl_t                  wr;
	logic                     smp_we;
	logic [DATA_W-1:0]        smp_mem [N];
	logic [KW-1:0]            cnt_q;
	logic [KW-1:0]            drn_q;
	logic                     feeding, capture, done_q;
	strm_ctl_t                smp_ctl_s1;
	logic signed [DATA_W-1:0] smp_x_s1;
	logic [KW-1:0]            smp_k_s1;
	strm_ctl_t                ctl_chain [N+1];
	logic signed [DATA_W-1:0] x_chain   [N+1];
	logic [KW-1:0]            k_chain   [N+1];
	logic [ACT_W-1:0]         res_chain [N+1];

	assign in_acc  = item.valid && item.ready;
	assign out_acc = result.valid && result.ready;

	// index range checks and width adaption of the payload
	assign k_ok  = (int'(item.input_index) < N);
	assign j_ok  = (int'(item.neuron_index) < N);
	assign k_idx = KW'(item.input_index);

	generate
		if (DATA_W <= VAL_W) begin : g_val_wrap
			assign val_d = item.value[DATA_W-1:0];
		end else begin : g_val_sext
			assign val_d = {{(DATA_W - VAL_W){item.value[VAL_W-1]}}, item.value};
		end
		if (ACC_W <= BIAS_W) begin : g_bias_wrap
			assign bias_d = item.bias_value[ACC_W-1:0];
		end else begin : g_bias_sext
			assign bias_d = {{(ACC_W - BIAS_W){item.bias_value[BIAS_W-1]}}, item.bias_value};
		end
	endgenerate

	// command decode
	assign wr.wen = in_acc && (item.cmd == CMD_WEIGHT) && k_ok && j_ok;
	assign wr.ben = in_acc && (item.cmd == CMD_BIAS) && j_ok;
	assign smp_we = in_acc && (item.cmd == CMD_SAMPLE) && k_ok;

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && (item.cmd == CMD_SAMPLE) && item.sample_last) begin
					state_d = ST_FEED;
				end
			end
			ST_FEED: begin
				if (cnt_q == K_LAST) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (done_q) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (out_acc && (drn_q == K_LAST)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer: outputs
	always_comb begin
		item.ready   = 1'b0;
		result.valid = 1'b0;
		feeding      = 1'b0;
		capture      = 1'b0;
		unique case (state_q)
			ST_IDLE:  item.ready   = 1'b1;
			ST_FEED:  feeding      = 1'b1;
			ST_FLUSH: ;
			ST_LOAD:  capture      = 1'b1;
			ST_DRAIN: result.valid = 1'b1;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// feed and drain counters, end-of-stream flag from the last cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			drn_q      <= '0;
			done_q     <= 1'b0;
			smp_ctl_s1 <= '0;
		end else begin
			if (feeding) begin
				cnt_q <= (cnt_q == K_LAST) ? '0 : cnt_q + KW'(1);
			end
			if (out_acc) begin
				drn_q <= (drn_q == K_LAST) ? '0 : drn_q + KW'(1);
			end
			done_q           <= ctl_chain[N].v && ctl_chain[N].last;
			smp_ctl_s1.v     <= feeding;
			smp_ctl_s1.first <= feeding && (cnt_q == '0);
			smp_ctl_s1.last  <= feeding && (cnt_q == K_LAST);
		end
	end

	// sample buffer, read in index order during the feed
	always_ff @(posedge clk) begin
		if (smp_we) begin
			smp_mem[k_idx] <= val_d;
		end
		smp_x_s1 <= smp_mem[cnt_q];
		smp_k_s1 <= cnt_q;
	end

	assign ctl_chain[0] = smp_ctl_s1;
	assign x_chain[0]   = smp_x_s1;
	assign k_chain[0]   = smp_k_s1;
	assign res_chain[N] = '0;

	// row of neuron cells
	generate
		for (genvar j = 0; j < N; j++) begin : g_cell
			dlr_cell #(
				.N        (N),
				.DATA_W   (DATA_W),
				.ACC_W    (ACC_W),
				.CELL_IDX (j)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.wr        (wr),
				.wr_neuron (item.neuron_index),
				.wr_k      (k_idx),
				.wr_w      (val_d),
				.wr_b      (bias_d),
				.ctl_in    (ctl_chain[j]),
				.x_in      (x_chain[j]),
				.k_in      (k_chain[j]),
				.ctl_out   (ctl_chain[j+1]),
				.x_out     (x_chain[j+1]),
				.k_out     (k_chain[j+1]),
				.capture   (capture),
				.shift     (out_acc),
				.res_in    (res_chain[j+1]),
				.res_out   (res_chain[j])
			);
		end
	endgenerate

	// result payload from the head of the chain
	assign result.out_neuron     = IDX_W'(drn_q);
	assign result.activation     = res_chain[0];
	assign result.last_of_sample = (drn_q == K_LAST);

	// checks
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(item.ready && result.valid))
		else $error("input taken while results pending");

	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && result.last_of_sample |=> item.ready)
		else $error("not idle after final activation");

	a_tail_index: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_chain[N].v && ctl_chain[N].last |-> k_chain[N] == K_LAST)
		else $error("stream end carries wrong index");

	a_done_flush: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_FLUSH)
		else $error("stream end outside flush");

endmodule

`default_nettype wire

FILE: test/dlr_act_check.sv
// Activation checker for the dense layer: mirrors the stores and compares every result.
`timescale 1ns / 100ps

module dlr_act_check (
	input  logic clk,
	input  logic arst_n,
	dlr_in_if    item,
	dlr_out_if   result,
	output int   mismatches,
	output int   outstanding
);
	import dlr_pkg::*;

	localparam int N      = N_DEF;
	localparam int DATA_W = DATA_W_DEF;
	localparam int ACC_W  = ACC_W_DEF;

	typedef struct packed {
		logic [IDX_W-1:0] neuron;
		logic [ACT_W-1:0] act;
		logic             last;
	} activation_t;

	// Local copies of the three stores, weights indexed [input][neuron]
	logic signed [DATA_W-1:0] weight_mem [N][N];
	logic signed [ACC_W-1:0]  bias_mem [N];
	logic signed [DATA_W-1:0] sample_mem [N];
	activation_t              expected_acts [$];

	int fail_count = 0;
	int queued     = 0;

	assign mismatches  = fail_count;
	assign outstanding = queued;

	function automatic void flag(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t activation check: %s", $time, msg);
	endfunction

	// One activation per neuron: ReLU of bias plus dot product, summed modulo 2^ACC_W
	function automatic void predict_sample();
		logic signed [ACC_W-1:0] acc;
		activation_t             a;
		for (int j = 0; j < N; j++) begin
			acc = bias_mem[j];
			for (int k = 0; k < N; k++)
				acc = acc + ACC_W'(sample_mem[k]) * ACC_W'(weight_mem[k][j]);
			if (acc[ACC_W-1])
				a.act = '0;
			else if ($unsigned(acc) > {ACT_W{1'b1}})
				a.act = '1;   // only reachable with an accumulator wider than 32 bits
			else
				a.act = acc[ACT_W-1:0];
			a.neuron = IDX_W'(j);
			a.last   = (j == N - 1);
			expected_acts.push_back(a);
		end
	endfunction

	always @(posedge clk) begin
		activation_t want;
		if (arst_n) begin
			// results first: a command taken at this edge cannot own them
			if (result.valid && result.ready) begin
				if (expected_acts.size() == 0) begin
					flag($sformatf("unexpected result neuron %0d act %0d last %0b",
						result.out_neuron, result.activation, result.last_of_sample));
				end else begin
					want = expected_acts.pop_front();
					if (result.out_neuron !== want.neuron || result.activation !== want.act ||
							result.last_of_sample !== want.last) begin
						flag($sformatf("neuron %0d/%0d act %0d/%0d last %0b/%0b (exp/got)",
							want.neuron, result.out_neuron, want.act, result.activation,
							want.last, result.last_of_sample));
					end
				end
			end
			// command transactions update the local stores
			if (item.valid && item.ready) begin
				case (item.cmd)
					CMD_WEIGHT: begin
						if (int'(item.input_index) < N && int'(item.neuron_index) < N)
							weight_mem[item.input_index][item.neuron_index] =
								item.value[DATA_W-1:0];
					end
					CMD_BIAS: begin
						if (int'(item.neuron_index) < N)
							bias_mem[item.neuron_index] = ACC_W'(item.bias_value);
					end
					CMD_SAMPLE: begin
						if (int'(item.input_index) < N)
							sample_mem[item.input_index] = item.value[DATA_W-1:0];
						if (item.sample_last)
							predict_sample();
					end
					default: ;   // unused code, ignored by the block
				endcase
			end
			queued = expected_acts.size();
		end
	end

endmodule

FILE: test/dense_layer_relu_test.sv
// Testbench top of the dense layer with ReLU: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module dense_layer_relu_test;
	import dlr_pkg::*;

	localparam int N            = N_DEF;
	localparam int ITEM_GOAL    = 460;
	localparam int DRAIN_CYCLES = 3 * N + 3;
	localparam int IDLE_LIMIT   = 500;

	localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
	localparam logic [VAL_W-1:0]  VAL_MIN    = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [VAL_W-1:0]  VAL_MAX    = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [BIAS_W-1:0] BIAS_MIN   = {1'b1, {(BIAS_W-1){1'b0}}};
	localparam logic [BIAS_W-1:0] BIAS_MAX   = {1'b0, {(BIAS_W-1){1'b1}}};

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   items_sent  = 0;
	int   idle_cycles = 0;
	bit   src_gaps    = 1'b1;
	bit   snk_stalls  = 1'b1;

	dlr_in_if  item ();
	dlr_out_if result ();

	dense_layer_relu dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result)
	);

	dlr_act_check act_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.result      (result),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Random operands, with the extremes drawn often
	function automatic logic [VAL_W-1:0] rand_val();
		case ($urandom_range(0, 7))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return VAL_W'($urandom_range(0, 3)) - VAL_W'(1);
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic logic [BIAS_W-1:0] rand_bias();
		case ($urandom_range(0, 7))
			0: return BIAS_MIN;
			1: return BIAS_MAX;
			2: return BIAS_W'($urandom_range(0, 3)) - BIAS_W'(1);
			default: return BIAS_W'($urandom);
		endcase
	endfunction

	// One command transaction; valid stays high across back-to-back transactions
	task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] k,
			input logic [IDX_W-1:0] j, input logic [VAL_W-1:0] val,
			input logic [BIAS_W-1:0] bias, input logic last);
		int gap;
		gap = src_gaps ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid        <= 1'b1;
		item.cmd          <= cmd;
		item.input_index  <= k;
		item.neuron_index <= j;
		item.value        <= val;
		item.bias_value   <= bias;
		item.sample_last  <= last;
		do @(posedge clk); while (!item.ready);
		if (cmd != CMD_UNUSED)
			items_sent++;
	endtask

	// Unused fields are random; the last flag too where it is ignored
	task automatic write_weight(input int k, input int j, input logic [VAL_W-1:0] v);
		send_cmd(CMD_WEIGHT, IDX_W'(k), IDX_W'(j), v, BIAS_W'($urandom), 1'($urandom));
	endtask

	task automatic write_bias(input int j, input logic [BIAS_W-1:0] b);
		send_cmd(CMD_BIAS, IDX_W'($urandom), IDX_W'(j), VAL_W'($urandom), b, 1'($urandom));
	endtask

	task automatic feed(input int k, input logic [VAL_W-1:0] v, input logic last);
		send_cmd(CMD_SAMPLE, IDX_W'(k), IDX_W'($urandom), v, BIAS_W'($urandom), last);
	endtask

	// Result side: a random hold-off before each result transaction
	initial begin
		int hold;
		result.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = snk_stalls ? $urandom_range(0, 3) : 0;
			if (hold > 0) begin
				result.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
		end
	end

	// Command stimulus and verdict
	initial begin
		int n_extra;
		int pick;
		item.valid        <= 1'b0;
		item.cmd          <= CMD_WEIGHT;
		item.input_index  <= '0;
		item.neuron_index <= '0;
		item.value        <= '0;
		item.bias_value   <= '0;
		item.sample_last  <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// fill every store before the first computation reads it
		for (int k = 0; k < N; k++)
			for (int j = 0; j < N; j++)
				write_weight(k, j, rand_val());
		for (int j = 0; j < N; j++)
			write_bias(j, rand_bias());
		for (int k = 0; k < N; k++)
			feed(k, rand_val(), k == N - 1);

		// unused code and last flag on writes: ignored, no results
		send_cmd(CMD_UNUSED, IDX_W'($urandom), IDX_W'($urandom), rand_val(), rand_bias(), 1'b1);
		send_cmd(CMD_WEIGHT, IDX_W'(N - 1), IDX_W'(N - 1), VAL_MIN, rand_bias(), 1'b1);
		send_cmd(CMD_BIAS, IDX_W'($urandom), '0, rand_val(), BIAS_MIN, 1'b1);
		write_bias(N - 1, BIAS_MAX);
		write_bias(1, '0);
		write_bias(2, BIAS_W'(1));
		write_weight(0, 0, VAL_MAX);
		// all-zero sample: each activation is the ReLU of its bias alone
		for (int k = 0; k < N; k++)
			feed(k, '0, k == N - 1);
		// single extreme element against the stored weights
		feed(0, VAL_MIN, 1'b1);
		feed(0, VAL_MAX, 1'b1);

		// random rounds: a few store updates and noise, closed by a final element
		while (items_sent < ITEM_GOAL) begin
			pick       = $urandom_range(0, 3);
			src_gaps   = pick[0];
			snk_stalls = pick[1];
			n_extra    = $urandom_range(0, 12);
			repeat (n_extra) begin
				pick = $urandom_range(0, 19);
				if (pick < 8)
					write_weight($urandom_range(0, N - 1), $urandom_range(0, N - 1), rand_val());
				else if (pick < 11)
					write_bias($urandom_range(0, N - 1), rand_bias());
				else if (pick < 18)
					feed($urandom_range(0, N - 1), rand_val(), 1'b0);
				else
					send_cmd(CMD_UNUSED, IDX_W'($urandom), IDX_W'($urandom), rand_val(),
						rand_bias(), 1'($urandom));
			end
			feed($urandom_range(0, N - 1), rand_val(), 1'b1);
		end
		item.valid <= 1'b0;
		@(posedge clk);

		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("dense_layer_relu: match");
		else
			$display("dense_layer_relu: mismatch");
		$finish;
	end

	// Watchdog: too long without any transaction on either side
	always @(posedge clk) begin
		if (!arst_n || (item.valid && item.ready) || (result.valid && result.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("dense_layer_relu: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
